>>> rtl/mst_pkg.sv
package mst_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int TICK_WIDTH_DEF = 32;

  localparam int CMD_W      = 3;
  localparam int ID_W       = 3;
  localparam int PERIOD_W   = 32;
  localparam int MASK_W     = 8;
  localparam int TICK_OUT_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ONESHOT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PERIODIC = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd4;

  typedef struct packed {
    logic [MASK_W-1:0]     fired_mask;
    logic [ID_W-1:0]       new_slot;
    logic                  allocate_ok;
    logic [TICK_OUT_W-1:0] tick_count;
  } result_t;

endpackage

>>> rtl/mst_slot_ram.sv
module mst_slot_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 66
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/mst_ctrl.sv
module mst_ctrl #(
  parameter int SLOTS      = 8,
  parameter int TICK_WIDTH = 32,
  parameter int SLOT_W     = 3,
  parameter int DATA_W     = 66
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  logic [mst_pkg::CMD_W-1:0]      cmd_command,
  input  logic [mst_pkg::ID_W-1:0]       cmd_slot_id,
  input  logic [mst_pkg::PERIOD_W-1:0]   cmd_period,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mst_pkg::result_t               res,
  output logic                           rd_en,
  output logic [SLOT_W-1:0]              rd_addr,
  input  logic [DATA_W-1:0]              rd_data,
  output logic                           wr_en,
  output logic [SLOT_W-1:0]              wr_addr,
  output logic [DATA_W-1:0]              wr_data
);

  import mst_pkg::*;

  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TOUT_W  = (TICK_WIDTH < TICK_OUT_W) ? TICK_WIDTH : TICK_OUT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [TICK_WIDTH-1:0] free_ticks_r, free_ticks_nxt;
  logic [CNT_W-1:0]      slots_used_r, slots_used_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [MASK_W-1:0]     fired_r, fired_nxt;
  logic [ID_W-1:0]       new_slot_r, new_slot_nxt;
  logic                  ok_r, ok_nxt;

  logic                  ent_enabled;
  logic                  ent_periodic;
  logic [TICK_WIDTH-1:0] ent_period;
  logic [TICK_WIDTH-1:0] ent_count;
  logic [TICK_WIDTH-1:0] cnt_inc;
  logic                  fire;
  logic                  id_ok;

  assign ent_enabled  = rd_data[DATA_W-1];
  assign ent_periodic = rd_data[DATA_W-2];
  assign ent_period   = rd_data[2*TICK_WIDTH-1:TICK_WIDTH];
  assign ent_count    = rd_data[TICK_WIDTH-1:0];
  assign cnt_inc      = ent_count + TICK_WIDTH'(1);
  assign fire         = ent_enabled && (cnt_inc >= ent_period);
  assign id_ok        = 32'(cmd_slot_id) < 32'(slots_used_r);

  always_comb begin
    state_nxt      = state_r;
    free_ticks_nxt = free_ticks_r;
    slots_used_nxt = slots_used_r;
    idx_nxt        = idx_r;
    fired_nxt      = fired_r;
    new_slot_nxt   = new_slot_r;
    ok_nxt         = ok_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    cmd_ready      = (state_r == ST_IDLE);
    res_valid      = (state_r == ST_DONE);
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          fired_nxt    = '0;
          new_slot_nxt = '0;
          ok_nxt       = 1'b0;
          state_nxt    = ST_DONE;
          case (cmd_command)
            CMD_TICK: begin
              free_ticks_nxt = free_ticks_r + TICK_WIDTH'(1);
              if (slots_used_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = ST_WALK;
              end
            end
            CMD_ALLOC: begin
              if (32'(slots_used_r) < SLOTS) begin
                wr_en          = 1'b1;
                wr_addr        = slots_used_r[SLOT_W-1:0];
                wr_data        = '0;
                new_slot_nxt   = ID_W'(slots_used_r);
                ok_nxt         = 1'b1;
                slots_used_nxt = slots_used_r + CNT_W'(1);
              end
            end
            CMD_ONESHOT, CMD_PERIODIC: begin
              if (id_ok) begin
                wr_en   = 1'b1;
                wr_addr = cmd_slot_id[SLOT_W-1:0];
                wr_data = {1'b1, (cmd_command == CMD_PERIODIC),
                           TICK_WIDTH'(cmd_period), {TICK_WIDTH{1'b0}}};
              end
            end
            CMD_STOP: begin
              if (id_ok) begin
                rd_en     = 1'b1;
                rd_addr   = cmd_slot_id[SLOT_W-1:0];
                idx_nxt   = cmd_slot_id[SLOT_W-1:0];
                state_nxt = ST_STOP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        wr_en   = 1'b1;
        wr_data = {fire ? ent_periodic : ent_enabled, ent_periodic, ent_period,
                   fire ? {TICK_WIDTH{1'b0}} : cnt_inc};
        if (fire) begin
          fired_nxt = fired_r | (MASK_W'(1) << idx_r);
        end
        if (32'(idx_r) + 32'd1 < 32'(slots_used_r)) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + SLOT_W'(1);
          idx_nxt = idx_r + SLOT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_STOP: begin
        wr_en     = 1'b1;
        wr_data   = {1'b0, rd_data[DATA_W-2:0]};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_ticks_r <= '0;
      slots_used_r <= '0;
    end else begin
      state_r      <= state_nxt;
      free_ticks_r <= free_ticks_nxt;
      slots_used_r <= slots_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    fired_r    <= fired_nxt;
    new_slot_r <= new_slot_nxt;
    ok_r       <= ok_nxt;
  end

  assign res.fired_mask  = fired_r;
  assign res.new_slot    = new_slot_r;
  assign res.allocate_ok = ok_r;
  assign res.tick_count  = TICK_OUT_W'(free_ticks_r[TOUT_W-1:0]);

endmodule

>>> rtl/multi_slot_soft_timer.sv
// multi_slot_soft_timer: bank of SLOTS software timers driven by commands
// (tick, allocate, start one-shot, start periodic, stop).
// input channel in_valid/in_ready carries in_command, in_slot_id, in_period;
// the result channel out_valid/out_ready gives one transaction per command:
// out_fired_mask, out_new_slot, out_allocate_ok, out_tick_count.
// slot state (enable, mode, period, counter) lives in a single-port-read,
// single-port-write ram with a registered read port.
// allocate, start and unknown commands do their work in the idle state, stop
// reads the slot and then writes it back, and a tick walks the allocated
// slots one per cycle through the ram read port.
// a result waits in the controller's done state after the work, then moves
// into the output register. the next command is taken once the previous
// result is in the output register, so a waiting result does not block it.
// if out_ready stays low, one result waits in the output register and one
// more in the controller; after that in_ready drops.
// synchronous reset clears tick count, allocation count and all handshake
// state; slot entries are written when a slot is allocated, so no clearing
// pass is needed.
module multi_slot_soft_timer #(
  parameter int SLOTS      = mst_pkg::SLOTS_DEF,
  parameter int TICK_WIDTH = mst_pkg::TICK_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mst_pkg::CMD_W-1:0]          in_command,
  input  logic [mst_pkg::ID_W-1:0]           in_slot_id,
  input  logic [mst_pkg::PERIOD_W-1:0]       in_period,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mst_pkg::MASK_W-1:0]         out_fired_mask,
  output logic [mst_pkg::ID_W-1:0]           out_new_slot,
  output logic                               out_allocate_ok,
  output logic [mst_pkg::TICK_OUT_W-1:0]     out_tick_count
);

  import mst_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DATA_W = 2 * TICK_WIDTH + 2;

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic              out_valid_r;
  result_t           out_res_r;

  mst_ctrl #(
    .SLOTS      (SLOTS),
    .TICK_WIDTH (TICK_WIDTH),
    .SLOT_W     (SLOT_W),
    .DATA_W     (DATA_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_valid),
    .cmd_ready   (in_ready),
    .cmd_command (in_command),
    .cmd_slot_id (in_slot_id),
    .cmd_period  (in_period),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  mst_slot_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (DATA_W)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register, refilled when empty or drained in the same cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired_mask  = out_res_r.fired_mask;
  assign out_new_slot    = out_res_r.new_slot;
  assign out_allocate_ok = out_res_r.allocate_ok;
  assign out_tick_count  = out_res_r.tick_count;

endmodule
